// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent checks, clocked on clk and reset by arst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent is checked in the same cycle as the antecedent.
`define ICV_ASSERT_IMPL(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent is checked in the cycle after the antecedent.
`define ICV_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/icv_pkg.sv =====
// ----------------------------------------------------------------------------
// 3x3 convolution package
// Types, sizes and codes shared by the convolution block and its submodules.
// ----------------------------------------------------------------------------
package icv_pkg;

	localparam int MAX_WIDTH = 1024;
	localparam int COL_W     = $clog2(MAX_WIDTH);
	localparam int CHANNELS  = 3;
	localparam int PIX_W     = 8 * CHANNELS;
	localparam int TAPS      = 3;
	localparam int PADDR_W   = 5;

	localparam int PIX_MAX     = 255;
	localparam int BOX_BIAS    = 4;
	localparam int BOX_RECIP   = 3641;
	localparam int BOX_SHIFT   = 15;
	localparam int GAUSS_BIAS  = 8;
	localparam int GAUSS_SHIFT = 4;

	typedef logic [PIX_W-1:0] pix_t;

	typedef struct packed {
		pix_t top;
		pix_t mid;
		pix_t bot;
	} col_t;

	typedef col_t [TAPS-1:0] win_t;

	typedef logic signed [13:0] sum_t;
	typedef sum_t [CHANNELS-1:0] sums_t;

	typedef enum logic [1:0] {
		FM_EDGE,
		FM_SHARPEN,
		FM_BOX,
		FM_GAUSS
	} filter_mode_t;

	typedef enum logic [2:0] {
		REG_FILTER_MODE,
		REG_IMAGE_WIDTH,
		REG_IMAGE_HEIGHT,
		REG_SEL_LEFT,
		REG_SEL_RIGHT,
		REG_SEL_TOP,
		REG_SEL_BOTTOM
	} reg_idx_t;

endpackage

// ===== src/icv_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module icv_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== src/icv_cell.sv =====
// ----------------------------------------------------------------------------
// Window cell
// Holds one three-pixel column of the window and passes it to its neighbor.
// ----------------------------------------------------------------------------
module icv_cell
	import icv_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic shift_en,
	input  col_t col_in,
	output col_t col_out
);

	col_t col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (shift_en) begin
			col_q <= col_in;
		end
	end

	assign col_out = col_q;

endmodule

// ===== src/icv_kernel.sv =====
// ----------------------------------------------------------------------------
// Kernel sums
// Weighted sums of the 3x3 window for each color channel and filter mode.
// ----------------------------------------------------------------------------
module icv_kernel
	import icv_pkg::*;
(
	input  win_t         win,
	input  filter_mode_t mode,
	output sums_t        sums
);

	logic [7:0] ctr  [CHANNELS];
	logic [9:0] edg  [CHANNELS];
	logic [9:0] cnr  [CHANNELS];

	function automatic logic [7:0] chan(pix_t p, int ch);
		return p[8*(CHANNELS-1-ch) +: 8];
	endfunction

	function automatic sum_t chan_sum(filter_mode_t m, logic [7:0] c8, logic [9:0] e10,
		logic [9:0] k10);
		sum_t c;
		sum_t e;
		sum_t k;
		sum_t s;
		c = sum_t'({6'd0, c8});
		e = sum_t'({4'd0, e10});
		k = sum_t'({4'd0, k10});
		case (m)
			FM_EDGE:    s = (c <<< 3) - e - k;
			FM_SHARPEN: s = (c <<< 2) + c - e;
			FM_BOX:     s = c + e + k;
			FM_GAUSS:   s = (c <<< 2) + (e <<< 1) + k;
			default:    s = c;
		endcase
		return s;
	endfunction

	always_comb begin
		for (int ch = 0; ch < CHANNELS; ch++) begin
			ctr[ch] = chan(win[1].mid, ch);
			edg[ch] = 10'(chan(win[1].top, ch)) + 10'(chan(win[1].bot, ch))
				+ 10'(chan(win[0].mid, ch)) + 10'(chan(win[2].mid, ch));
			cnr[ch] = 10'(chan(win[0].top, ch)) + 10'(chan(win[0].bot, ch))
				+ 10'(chan(win[2].top, ch)) + 10'(chan(win[2].bot, ch));
			sums[ch] = chan_sum(mode, ctr[ch], edg[ch], cnr[ch]);
		end
	end

endmodule

// ===== src/image_convolution_3x3.sv =====
// ----------------------------------------------------------------------------
// 3x3 image convolution
// Filters an RGB raster stream with a selectable 3x3 kernel inside a window.
// ----------------------------------------------------------------------------
//  channel  handshake              word
//  pix      pix_valid, pix_ready   red_in, green_in, blue_in, frame_start
//  res      res_valid, res_ready   red_out, green_out, blue_out, out_row, out_column
//  apb      psel, penable, pwrite  paddr, pwdata, prdata, pready
//
// One pixel per cycle while pix_ready is high; the line buffer RAM does one read and one write per pixel.
// res_valid rises once the last pixel of the window has passed the stage 1, 2, 3 and 4 registers.
// A stalled result stage fills the four pipeline stages before pix_ready drops.
// Reset clears the position, window and pipeline; there is no clearing pass.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module image_convolution_3x3
	import icv_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               pix_valid,
	output logic               pix_ready,
	input  logic [7:0]         red_in,
	input  logic [7:0]         green_in,
	input  logic [7:0]         blue_in,
	input  logic               frame_start,
	output logic               res_valid,
	input  logic               res_ready,
	output logic [7:0]         red_out,
	output logic [7:0]         green_out,
	output logic [7:0]         blue_out,
	output logic [15:0]        out_row,
	output logic [9:0]         out_column
);

	filter_mode_t mode_q;
	logic [10:0]  width_q;
	logic [15:0]  height_q;
	logic [10:0]  left_q;
	logic [10:0]  right_q;
	logic [15:0]  top_q;
	logic [15:0]  bottom_q;
	reg_idx_t     reg_idx;
	logic         wr_en;
	logic [10:0]  eff_w;
	logic [15:0]  eff_h;

	logic [COL_W-1:0] col_q;
	logic [15:0]      row_q;
	logic [10:0]      c_cur;
	logic [16:0]      r_tmp;
	logic [15:0]      r_cur;
	logic [10:0]      c_nxt;
	logic [16:0]      r_nxt;
	logic             acc;

	logic             v_s1;
	pix_t             pix_s1;
	logic [COL_W-1:0] col_s1;
	logic [15:0]      row_s1;
	logic             fwd_q;
	logic [2*PIX_W-1:0] fwd_data_q;
	logic [2*PIX_W-1:0] ram_q;
	logic [2*PIX_W-1:0] line_s1;
	pix_t             top_s1;
	pix_t             mid_s1;
	logic [15:0]      rr_s1;
	logic [COL_W-1:0] cc_s1;
	logic             emit_s1;
	logic             rdy1;
	logic             adv1;

	col_t             cell_in [TAPS];
	win_t             win;
	logic             v_s2;
	logic [15:0]      row_s2;
	logic [COL_W-1:0] col_s2;
	logic             rdy2;
	logic             adv2;
	sums_t            sums;

	logic             v_s3;
	sums_t            sum_s3;
	logic [15:0]      row_s3;
	logic [COL_W-1:0] col_s3;
	logic             rdy3;
	logic             adv3;

	logic             v_s4;
	logic [7:0]       red_s4;
	logic [7:0]       green_s4;
	logic [7:0]       blue_s4;
	logic [15:0]      row_s4;
	logic [COL_W-1:0] col_s4;
	logic             rdy_o;

	function automatic logic [7:0] finish(filter_mode_t m, sum_t s);
		logic [11:0] x;
		logic [23:0] prod;
		sum_t        t;
		logic [7:0]  r;
		x = s[11:0] + 12'(BOX_BIAS);
		prod = 24'(x) * 24'(BOX_RECIP);
		t = s + sum_t'(GAUSS_BIAS);
		case (m) inside
			FM_BOX:   r = prod[BOX_SHIFT +: 8];
			FM_GAUSS: r = t[GAUSS_SHIFT +: 8];
			FM_EDGE, FM_SHARPEN: begin
				if (s < 0) begin
					r = 8'd0;
				end else if (s > sum_t'(PIX_MAX)) begin
					r = 8'(PIX_MAX);
				end else begin
					r = s[7:0];
				end
			end
			default: r = 8'd0;
		endcase
		return r;
	endfunction

	// Register file.
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= FM_EDGE;
			width_q  <= 11'd1024;
			height_q <= 16'd1024;
			left_q   <= 11'd0;
			right_q  <= 11'd1024;
			top_q    <= 16'd0;
			bottom_q <= 16'hFFFF;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_FILTER_MODE:  mode_q   <= filter_mode_t'(pwdata[1:0]);
				REG_IMAGE_WIDTH:  width_q  <= pwdata[10:0];
				REG_IMAGE_HEIGHT: height_q <= pwdata[15:0];
				REG_SEL_LEFT:     left_q   <= pwdata[10:0];
				REG_SEL_RIGHT:    right_q  <= pwdata[10:0];
				REG_SEL_TOP:      top_q    <= pwdata[15:0];
				REG_SEL_BOTTOM:   bottom_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_FILTER_MODE:  prdata = {30'd0, mode_q};
			REG_IMAGE_WIDTH:  prdata = {21'd0, width_q};
			REG_IMAGE_HEIGHT: prdata = {16'd0, height_q};
			REG_SEL_LEFT:     prdata = {21'd0, left_q};
			REG_SEL_RIGHT:    prdata = {21'd0, right_q};
			REG_SEL_TOP:      prdata = {16'd0, top_q};
			REG_SEL_BOTTOM:   prdata = {16'd0, bottom_q};
			default:          prdata = 32'd0;
		endcase
	end

	always_comb begin
		if (width_q == 11'd0) begin
			eff_w = 11'd1;
		end else if (width_q > 11'(MAX_WIDTH)) begin
			eff_w = 11'(MAX_WIDTH);
		end else begin
			eff_w = width_q;
		end
		eff_h = (height_q == 16'd0) ? 16'd1 : height_q;
	end

	// Raster position of the incoming pixel and of the one after it.
	always_comb begin
		if (frame_start) begin
			c_cur = 11'd0;
			r_tmp = 17'd0;
		end else begin
			c_cur = {1'b0, col_q};
			r_tmp = {1'b0, row_q};
			if (c_cur >= eff_w) begin
				c_cur = 11'd0;
				r_tmp = r_tmp + 17'd1;
			end
			if (r_tmp >= {1'b0, eff_h}) begin
				r_tmp = 17'd0;
			end
		end
		r_cur = r_tmp[15:0];
		c_nxt = c_cur + 11'd1;
		r_nxt = {1'b0, r_cur};
		if (c_nxt >= eff_w) begin
			c_nxt = 11'd0;
			r_nxt = r_nxt + 17'd1;
			if (r_nxt >= {1'b0, eff_h}) begin
				r_nxt = 17'd0;
			end
		end
	end

	// Elastic pipeline control.
	assign rdy_o     = !v_s4 || res_ready;
	assign rdy3      = !v_s3 || rdy_o;
	assign rdy2      = !v_s2 || rdy3;
	assign rdy1      = !v_s1 || rdy2;
	assign adv1      = v_s1 && rdy2;
	assign adv2      = v_s2 && rdy3;
	assign adv3      = v_s3 && rdy_o;
	assign pix_ready = rdy1;
	assign acc       = pix_valid && rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			v_s1  <= 1'b0;
			fwd_q <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
		end else begin
			if (acc) begin
				col_q <= c_nxt[COL_W-1:0];
				row_q <= r_nxt[15:0];
				fwd_q <= adv1 && (col_s1 == c_cur[COL_W-1:0]);
			end
			if (rdy1) begin
				v_s1 <= acc;
			end
			if (rdy2) begin
				v_s2 <= adv1 && emit_s1;
			end
			if (rdy3) begin
				v_s3 <= v_s2;
			end
			if (rdy_o) begin
				v_s4 <= v_s3;
			end
		end
	end

	// Stage 1: line buffer read; the RAM word holds rows r-2 and r-1.
	always_ff @(posedge clk) begin
		if (acc) begin
			pix_s1     <= {red_in, green_in, blue_in};
			col_s1     <= c_cur[COL_W-1:0];
			row_s1     <= r_cur;
			fwd_data_q <= {mid_s1, pix_s1};
		end
	end

	icv_ram #(
		.WIDTH(2 * PIX_W),
		.DEPTH(MAX_WIDTH)
	) u_line_ram (
		.clk  (clk),
		.we   (adv1),
		.waddr(col_s1),
		.wdata({mid_s1, pix_s1}),
		.re   (acc),
		.raddr(c_cur[COL_W-1:0]),
		.rdata(ram_q)
	);

	assign line_s1 = fwd_q ? fwd_data_q : ram_q;
	assign top_s1  = line_s1[2*PIX_W-1:PIX_W];
	assign mid_s1  = line_s1[PIX_W-1:0];
	assign rr_s1   = row_s1 - 16'd1;
	assign cc_s1   = col_s1 - 10'd1;
	assign emit_s1 = (row_s1 >= 16'd2) && (col_s1 >= 10'd2)
		&& (rr_s1 >= top_q) && (rr_s1 < bottom_q)
		&& ({1'b0, cc_s1} >= left_q) && ({1'b0, cc_s1} < right_q);

	// Stage 2: the window is the chain of column cells.
	assign cell_in[0] = '{top: top_s1, mid: mid_s1, bot: pix_s1};

	for (genvar i = 0; i < TAPS; i++) begin : g_cell
		if (i > 0) begin : g_link
			assign cell_in[i] = win[i-1];
		end
		icv_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.shift_en(adv1),
			.col_in  (cell_in[i]),
			.col_out (win[i])
		);
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			row_s2 <= rr_s1;
			col_s2 <= cc_s1;
		end
	end

	icv_kernel u_kernel (
		.win (win),
		.mode(mode_q),
		.sums(sums)
	);

	// Stage 3: kernel sums.
	always_ff @(posedge clk) begin
		if (adv2) begin
			sum_s3 <= sums;
			row_s3 <= row_s2;
			col_s3 <= col_s2;
		end
	end

	// Stage 4: rounding division, clamping and the output register.
	always_ff @(posedge clk) begin
		if (adv3) begin
			red_s4   <= finish(mode_q, sum_s3[0]);
			green_s4 <= finish(mode_q, sum_s3[1]);
			blue_s4  <= finish(mode_q, sum_s3[2]);
			row_s4   <= row_s3;
			col_s4   <= col_s3;
		end
	end

	assign res_valid  = v_s4;
	assign red_out    = red_s4;
	assign green_out  = green_s4;
	assign blue_out   = blue_s4;
	assign out_row    = row_s4;
	assign out_column = col_s4;

	`ICV_ASSERT_IMPL(a_full_stall, !pix_ready, v_s1 && v_s2 && v_s3 && v_s4, "input stalled with a free stage")
	`ICV_ASSERT_NEXT(a_fwd_set, acc && adv1 && (col_s1 == c_cur[COL_W-1:0]), fwd_q, "missing line buffer bypass")
	`ICV_ASSERT_IMPL(a_center_interior, v_s2, (row_s2 != 16'd0) && (col_s2 != 10'd0), "window center on border")
	`ICV_ASSERT_NEXT(a_s3_hold, v_s3 && !rdy_o, v_s3 && $stable(sum_s3), "stage 3 lost its sums")

endmodule

// ===== dv/image_convolution_3x3_test.sv =====
// ----------------------------------------------------------------------------
// 3x3 convolution block test
// Streams raster frames through the filter under changing kernels, frame
// sizes and selections, and checks every filtered word against an in-bench
// model of the line buffers and the window, with idle and stall phases on
// both sides of the block.
// ----------------------------------------------------------------------------
module image_convolution_3x3_test;
	timeunit 1ns;
	timeprecision 1ps;

	import icv_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int SETTLE_CYCLES  = 12;
	localparam int PIXEL_TARGET   = 1850;

	typedef struct {
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [15:0] row;
		logic [9:0]  column;
	} conv_px_t;

	class window_filter_model;
		int kernel [4][9] = '{
			'{-1, -1, -1, -1, 8, -1, -1, -1, -1},
			'{ 0, -1,  0, -1, 5, -1,  0, -1,  0},
			'{ 1,  1,  1,  1, 1,  1,  1,  1,  1},
			'{ 1,  2,  1,  2, 4,  2,  1,  2,  1}
		};
		pix_t         lines [2*MAX_WIDTH];
		pix_t         cols [6];
		int unsigned  row_pos;
		int unsigned  col_pos;
		filter_mode_t mode;
		bit [10:0]    width;
		bit [10:0]    sel_left;
		bit [10:0]    sel_right;
		bit [15:0]    height;
		bit [15:0]    sel_top;
		bit [15:0]    sel_bottom;
		conv_px_t     filtered_due [$];
		int           mismatches;
		int           checked;

		function new();
			foreach (lines[i]) lines[i] = '0;
			foreach (cols[i]) cols[i] = '0;
			row_pos = 0;
			col_pos = 0;
			mode = FM_EDGE;
			width = 11'd1024;
			height = 16'd1024;
			sel_left = 11'd0;
			sel_right = 11'd1024;
			sel_top = 16'd0;
			sel_bottom = 16'hFFFF;
			mismatches = 0;
			checked = 0;
		endfunction

		function void set_reg(reg_idx_t idx, bit [31:0] value);
			case (idx)
				REG_FILTER_MODE:  mode = filter_mode_t'(value[1:0]);
				REG_IMAGE_WIDTH:  width = value[10:0];
				REG_IMAGE_HEIGHT: height = value[15:0];
				REG_SEL_LEFT:     sel_left = value[10:0];
				REG_SEL_RIGHT:    sel_right = value[10:0];
				REG_SEL_TOP:      sel_top = value[15:0];
				REG_SEL_BOTTOM:   sel_bottom = value[15:0];
				default:          ;
			endcase
		endfunction

		function int pending();
			return filtered_due.size();
		endfunction

		function void accept_pixel(bit [7:0] red, bit [7:0] green, bit [7:0] blue, bit fs);
			int unsigned wd;
			int unsigned ht;
			int unsigned row;
			int unsigned col;
			int unsigned cr;
			int unsigned cc;
			pix_t        px;
			pix_t        upper;
			pix_t        middle;
			pix_t        win [9];
			int          acc;
			bit [7:0]    chans [3];
			conv_px_t    want;
			wd = (width == 0) ? 1 : ((width > MAX_WIDTH) ? MAX_WIDTH : width);
			ht = (height == 0) ? 1 : height;
			if (fs) begin
				row = 0;
				col = 0;
			end else begin
				row = row_pos;
				col = col_pos;
				if (col >= wd) begin
					col = 0;
					row++;
				end
				if (row >= ht)
					row = 0;
			end
			px = {red, green, blue};
			upper = lines[MAX_WIDTH + col];
			middle = lines[col];
			lines[MAX_WIDTH + col] = middle;
			lines[col] = px;
			// Rows run oldest to newest, columns left to right.
			win = '{cols[0], cols[3], upper, cols[1], cols[4], middle, cols[2], cols[5], px};
			if (row >= 2 && col >= 2) begin
				cr = row - 1;
				cc = col - 1;
				if (cr >= sel_top && cr < sel_bottom && cc >= sel_left && cc < sel_right) begin
					for (int ch = 0; ch < 3; ch++) begin
						acc = 0;
						for (int t = 0; t < 9; t++)
							acc += kernel[int'(mode)][t] * int'(win[t][8*(2-ch) +: 8]);
						if (mode == FM_BOX)
							acc = (acc + 4) / 9;
						else if (mode == FM_GAUSS)
							acc = (acc + 8) / 16;
						if (acc < 0)
							acc = 0;
						if (acc > 255)
							acc = 255;
						chans[ch] = acc[7:0];
					end
					want.red = chans[0];
					want.green = chans[1];
					want.blue = chans[2];
					want.row = cr[15:0];
					want.column = cc[9:0];
					filtered_due.push_back(want);
				end
			end
			cols[0] = cols[3];
			cols[1] = cols[4];
			cols[2] = cols[5];
			cols[3] = upper;
			cols[4] = middle;
			cols[5] = px;
			col++;
			if (col >= wd) begin
				col = 0;
				row++;
				if (row >= ht)
					row = 0;
			end
			row_pos = row;
			col_pos = col;
		endfunction

		function void check_pixel(conv_px_t got);
			conv_px_t want;
			checked++;
			if (filtered_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected filtered word at row %0d column %0d", got.row, got.column);
				return;
			end
			want = filtered_due.pop_front();
			if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
			    got.row !== want.row || got.column !== want.column) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Mismatch: expected r%0d c%0d rgb %h %h %h, got r%0d c%0d rgb %h %h %h",
						want.row, want.column, want.red, want.green, want.blue,
						got.row, got.column, got.red, got.green, got.blue);
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;
	logic               pix_valid;
	logic               pix_ready;
	logic [7:0]         red_in;
	logic [7:0]         green_in;
	logic [7:0]         blue_in;
	logic               frame_start;
	logic               res_valid;
	logic               res_ready;
	logic [7:0]         red_out;
	logic [7:0]         green_out;
	logic [7:0]         blue_out;
	logic [15:0]        out_row;
	logic [9:0]         out_column;

	window_filter_model model = new();
	int                 tx_pct;
	int                 rx_pct;
	int                 phase_no;
	int                 settings;
	int                 pixels_sent;
	int                 quiet_cycles;
	int unsigned        cur_width;
	bit                 restart_due;

	image_convolution_3x3 dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.pix_valid(pix_valid),
		.pix_ready(pix_ready),
		.red_in(red_in),
		.green_in(green_in),
		.blue_in(blue_in),
		.frame_start(frame_start),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.red_out(red_out),
		.green_out(green_out),
		.blue_out(blue_out),
		.out_row(out_row),
		.out_column(out_column)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		res_ready <= ($urandom_range(99) >= rx_pct);
	end

	always @(posedge clk) begin
		if (arst_n && pix_valid && pix_ready)
			model.accept_pixel(red_in, green_in, blue_in, frame_start);
		if (arst_n && res_valid && res_ready)
			model.check_pixel(conv_px_t'{red_out, green_out, blue_out, out_row, out_column});
	end

	always @(posedge clk) begin
		if (!arst_n || (pix_valid && pix_ready) || (res_valid && res_ready) || psel)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Watchdog: %0d cycles without a word moving", quiet_cycles);
			$display("image_convolution_3x3 test failed");
			$finish;
		end
	end

	task automatic write_reg(reg_idx_t idx, bit [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		model.set_reg(idx, value);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drained(bit settle);
		pix_valid <= 1'b0;
		do @(posedge clk); while (model.pending() != 0);
		if (settle)
			repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic configure(filter_mode_t fm, int unsigned w, int unsigned h,
	                         int unsigned l, int unsigned r, int unsigned t, int unsigned b);
		int unsigned ew;
		wait_drained(1'b1);
		write_reg(REG_FILTER_MODE, fm);
		write_reg(REG_IMAGE_WIDTH, w);
		write_reg(REG_IMAGE_HEIGHT, h);
		write_reg(REG_SEL_LEFT, l);
		write_reg(REG_SEL_RIGHT, r);
		write_reg(REG_SEL_TOP, t);
		write_reg(REG_SEL_BOTTOM, b);
		// A wider row would read line buffer columns that hold no pixel yet.
		ew = (w == 0) ? 1 : ((w > MAX_WIDTH) ? MAX_WIDTH : w);
		if (ew > cur_width)
			restart_due = 1'b1;
		cur_width = ew;
		settings++;
	endtask

	task automatic send_pixel(pix_t px, bit fs);
		if ($urandom_range(99) < tx_pct) begin
			pix_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < tx_pct);
		end
		pix_valid <= 1'b1;
		{red_in, green_in, blue_in} <= px;
		frame_start <= fs;
		do @(posedge clk); while (!pix_ready);
		pixels_sent++;
	endtask

	function automatic bit [7:0] rand_chan();
		case ($urandom_range(9))
			0:       return 8'd0;
			1:       return 8'd255;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	task automatic set_idling();
		case (phase_no % 4)
			0: begin
				tx_pct = 0;
				rx_pct = 0;
			end
			1: begin
				tx_pct = 47;
				rx_pct = 0;
			end
			2: begin
				tx_pct = 0;
				rx_pct = 47;
			end
			default: begin
				tx_pct = 31;
				rx_pct = 31;
			end
		endcase
		phase_no++;
	endtask

	task automatic run_phase(int n, bit fs_first, bit hold_once);
		int pause_at;
		bit fs;
		set_idling();
		pause_at = -1;
		if (hold_once || $urandom_range(4) == 0)
			pause_at = $urandom_range(n - 1);
		for (int i = 0; i < n; i++) begin
			fs = (i == 0) ? (fs_first || restart_due) : ($urandom_range(99) < 2);
			if (i == pause_at)
				wait_drained(1'b0);
			send_pixel({rand_chan(), rand_chan(), rand_chan()}, fs);
		end
		restart_due = 1'b0;
	endtask

	initial begin
		pix_t        pattern [18];
		int unsigned w;
		int unsigned h;
		int unsigned l;
		int unsigned r;
		int unsigned t;
		int unsigned b;
		bit          hold_once;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		pix_valid = 1'b0;
		red_in = '0;
		green_in = '0;
		blue_in = '0;
		frame_start = 1'b0;
		res_ready = 1'b0;
		tx_pct = 0;
		rx_pct = 0;
		phase_no = 0;
		settings = 0;
		pixels_sent = 0;
		quiet_cycles = 0;
		cur_width = MAX_WIDTH;
		restart_due = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// A bright dot on black, a white row, then mixed rows: each new row of a
		// three wide frame yields one word, so each kernel gets its own row.
		pattern = '{24'h000000, 24'h000000, 24'h000000,
		            24'h000000, 24'hFFFFFF, 24'h000000,
		            24'h000000, 24'h000000, 24'h000000,
		            24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
		            24'h0180FE, 24'h7F00FF, 24'h102030,
		            24'hFF0080, 24'hAA550F, 24'h00FF01};
		configure(FM_EDGE, 3, 6, 0, 1024, 0, 65535);
		set_idling();
		for (int i = 0; i < 18; i++) begin
			if (i >= 9 && i % 3 == 0) begin
				wait_drained(1'b1);
				write_reg(REG_FILTER_MODE, i / 3 - 2);
			end
			send_pixel(pattern[i], i == 0);
		end

		configure(FM_SHARPEN, 1024, 1024, 0, 1024, 0, 65535);
		run_phase(30, 1'b1, 1'b0);
		configure(FM_EDGE, 8, 1024, 0, 1024, 0, 65535);
		run_phase(60, 1'b0, 1'b0);
		configure(FM_GAUSS, 8, 4, 0, 1024, 0, 65535);
		run_phase(40, 1'b0, 1'b0);
		configure(FM_BOX, 0, 0, 0, 1024, 0, 65535);
		run_phase(20, 1'b0, 1'b0);
		configure(FM_EDGE, 1025, 3, 0, 1024, 0, 65535);
		run_phase(40, 1'b1, 1'b0);
		configure(FM_SHARPEN, 5, 3, 0, 1024, 0, 65535);
		run_phase(60, 1'b0, 1'b0);
		configure(FM_BOX, 6, 65535, 3, 3, 0, 65535);
		run_phase(40, 1'b0, 1'b0);
		configure(FM_GAUSS, 6, 8, 0, 1024, 5, 2);
		run_phase(40, 1'b0, 1'b0);
		configure(FM_EDGE, 7, 9, 1024, 0, 65535, 0);
		run_phase(30, 1'b0, 1'b0);
		configure(FM_SHARPEN, 1, 1, 0, 1024, 0, 65535);
		run_phase(12, 1'b0, 1'b0);
		configure(FM_BOX, 3, 65535, 1, 2, 1, 65535);
		run_phase(60, 1'b0, 1'b0);

		hold_once = 1'b1;
		while (pixels_sent < PIXEL_TARGET) begin
			case ($urandom_range(9))
				0:       w = $urandom_range(2);
				1:       w = $urandom_range(40, 13);
				default: w = $urandom_range(12, 3);
			endcase
			case ($urandom_range(9))
				0:       h = $urandom_range(2);
				1:       h = $urandom_range(30, 11);
				default: h = $urandom_range(10, 3);
			endcase
			case ($urandom_range(9))
				5, 6, 7, 8: begin
					l = $urandom_range(w);
					r = $urandom_range(w, l);
					t = $urandom_range(h);
					b = $urandom_range(h + 1, t);
				end
				9: begin
					l = $urandom_range(1024);
					r = $urandom_range(1024);
					t = $urandom_range(65535);
					b = $urandom_range(65535);
				end
				default: begin
					l = 0;
					r = 1024;
					t = 0;
					b = 65535;
				end
			endcase
			configure(filter_mode_t'($urandom_range(3)), w, h, l, r, t, b);
			run_phase($urandom_range(120, 40), $urandom_range(1), hold_once);
			hold_once = 1'b0;
		end

		wait_drained(1'b1);
		$display("Sent %0d pixels under %0d register settings and checked %0d filtered words,",
			pixels_sent, settings, model.checked);
		$display("covering all four kernels, odd frame sizes, mid-frame resizing and empty selections.");
		if (model.pending() != 0)
			$display("%0d expected words never arrived", model.pending());
		if (model.mismatches == 0 && model.pending() == 0)
			$display("image_convolution_3x3 test passed");
		else
			$display("image_convolution_3x3 test failed");
		$finish;
	end

endmodule
